/* rtl/hsb_pkg.sv */
// shared types, constants and constant tables for the colour point to frames block
// no dependencies; imported by the top level and its checker
`timescale 1ns / 1ps

package hsb_pkg;

  localparam int FULL_LEVEL = 450;
  localparam int HUE_STEP   = 37;
  localparam int SECTOR_LEN = 12;
  localparam int SCALE_MAX  = 31;
  localparam int HUE_CODES  = 128;
  localparam int SAT_CODES  = 32;

  // reciprocal constants: p / 31 for p < 2**14, x / 20 for x < 2**9
  localparam int RECIP31       = 16913;
  localparam int RECIP31_SHIFT = 19;
  localparam int RECIP20       = 410;
  localparam int RECIP20_SHIFT = 13;

  localparam logic [1:0] MODE_BREATHE = 2'd1;
  localparam logic [1:0] MODE_BLINK   = 2'd2;

  localparam logic [1:0]  FM_HOLD  = 2'd1;
  localparam logic [1:0]  FM_FADE  = 2'd2;
  localparam logic [11:0] FT_SHORT = 12'd1000;
  localparam logic [11:0] FT_LONG  = 12'd4000;

  typedef enum logic [2:0] {
    SEC_BG  = 3'd0,
    SEC_GB  = 3'd1,
    SEC_RG  = 3'd2,
    SEC_RG2 = 3'd3,
    SEC_RB  = 3'd4,
    SEC_BR  = 3'd5
  } sector_t;

  typedef struct packed {
    logic [6:0] hue;
    logic [4:0] saturation;
    logic [4:0] brightness;
    logic [1:0] play_mode;
  } point_t;

  typedef struct packed {
    logic [8:0]  red_first;
    logic [8:0]  green_first;
    logic [8:0]  blue_first;
    logic [8:0]  red_second;
    logic [8:0]  green_second;
    logic [8:0]  blue_second;
    logic [1:0]  frame_mode;
    logic [11:0] frame_time;
  } frames_t;

  // entry = {sector, k}; hues past the last sector stay in the last one
  function automatic logic [HUE_CODES-1:0][6:0] build_hue_table();
    logic [HUE_CODES-1:0][6:0] t;
    int sec;
    for (int i = 0; i < HUE_CODES; i++) begin
      sec = i / SECTOR_LEN;
      if (sec > 5) sec = 5;
      t[i] = {3'(sec), 4'(i % SECTOR_LEN)};
    end
    return t;
  endfunction

  // whitening term (31 - sat) * 450 / 31
  function automatic logic [SAT_CODES-1:0][8:0] build_sat_table();
    logic [SAT_CODES-1:0][8:0] t;
    for (int i = 0; i < SAT_CODES; i++) begin
      t[i] = 9'(((SCALE_MAX - i) * FULL_LEVEL) / SCALE_MAX);
    end
    return t;
  endfunction

  localparam logic [HUE_CODES-1:0][6:0] HUE_TABLE = build_hue_table();
  localparam logic [SAT_CODES-1:0][8:0] SAT_TABLE = build_sat_table();

endpackage

/* rtl/hue_sat_brt_to_rgb_frames_top.sv */
// colour point (hue, saturation, brightness, play mode) to two led frames
// depends on hsb_pkg for types, constants and lookup tables
`timescale 1ns / 1ps

// One colour point is taken per clock cycle: busy stays low, so every cycle with start
// high accepts an item. Each result appears on frames with done high for exactly one
// cycle, after passing through the five register stages (input, sector base and
// whitening lookup, clamp and brightness multiply, divide by 31 through a reciprocal
// multiply, frame two and output). Results come out in input order and cannot be held
// off, so the receiver must capture frames whenever done is high.
module hue_sat_brt_to_rgb_frames_top
  import hsb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  point_t  point,
  output logic    done,
  output frames_t frames
);

  // stage 0: input register
  logic   v0;
  point_t pt0;

  // stage 1: channel bases and whitening term
  logic       v1;
  logic [8:0] base1 [3];
  logic [8:0] sat1;
  logic [4:0] brt1;
  logic [1:0] mode1;

  // stage 2: clamped level times brightness
  logic        v2;
  logic [13:0] prod2 [3];
  logic [1:0]  mode2;

  // stage 3: first frame levels
  logic       v3;
  logic [8:0] lvl3 [3];
  logic [1:0] mode3;

  sector_t    sec;
  logic [3:0] k;
  logic [8:0] up;
  logic [8:0] down;
  logic [8:0] base_next [3];
  logic [8:0] sat_next;
  frames_t    frames_next;

  assign busy = 1'b0;

  always_comb begin
    sec  = sector_t'(HUE_TABLE[pt0.hue][6:4]);
    k    = HUE_TABLE[pt0.hue][3:0];
    up   = 9'(k) * 9'(HUE_STEP);
    down = 9'(SECTOR_LEN * HUE_STEP) - up;
    sat_next = SAT_TABLE[pt0.saturation];
    base_next[0] = 9'(FULL_LEVEL);
    base_next[1] = 9'(FULL_LEVEL);
    base_next[2] = 9'(FULL_LEVEL);
    case (sec)
      SEC_BG: begin
        base_next[0] = '0;
        base_next[1] = up;
      end
      SEC_GB: begin
        base_next[0] = '0;
        base_next[2] = down;
      end
      SEC_RG: begin
        base_next[0] = up;
        base_next[2] = '0;
      end
      SEC_RG2: begin
        base_next[1] = down;
        base_next[2] = '0;
      end
      SEC_RB: begin
        base_next[1] = '0;
        base_next[2] = up;
      end
      SEC_BR: begin
        base_next[0] = down;
        base_next[1] = '0;
      end
      default: begin
        base_next[0] = down;
        base_next[1] = '0;
      end
    endcase
  end

  logic [9:0]  sum2  [3];
  logic [8:0]  clamp2 [3];
  logic [28:0] q31   [3];
  logic [17:0] q20   [3];
  logic [8:0]  second [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum2[c]   = 10'(base1[c]) + 10'(sat1);
      clamp2[c] = (sum2[c] > 10'(FULL_LEVEL)) ? 9'(FULL_LEVEL) : sum2[c][8:0];
      q31[c]    = 29'(prod2[c]) * 29'(RECIP31);
      q20[c]    = 18'(lvl3[c]) * 18'(RECIP20);
    end
    case (mode3)
      MODE_BLINK: begin
        for (int c = 0; c < 3; c++) second[c] = '0;
        frames_next.frame_mode = FM_HOLD;
        frames_next.frame_time = FT_SHORT;
      end
      MODE_BREATHE: begin
        for (int c = 0; c < 3; c++) begin
          second[c] = 9'(q20[c][17:RECIP20_SHIFT]) + 9'd1;
        end
        frames_next.frame_mode = FM_FADE;
        frames_next.frame_time = FT_LONG;
      end
      default: begin
        for (int c = 0; c < 3; c++) second[c] = lvl3[c];
        frames_next.frame_mode = FM_HOLD;
        frames_next.frame_time = FT_SHORT;
      end
    endcase
    frames_next.red_first    = lvl3[0];
    frames_next.green_first  = lvl3[1];
    frames_next.blue_first   = lvl3[2];
    frames_next.red_second   = second[0];
    frames_next.green_second = second[1];
    frames_next.blue_second  = second[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0   <= 1'b0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v0   <= start && !busy;
      v1   <= v0;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    pt0 <= point;
    for (int c = 0; c < 3; c++) begin
      base1[c] <= base_next[c];
      prod2[c] <= 14'(clamp2[c]) * 14'(brt1);
      lvl3[c]  <= q31[c][RECIP31_SHIFT+8:RECIP31_SHIFT];
    end
    sat1   <= sat_next;
    brt1   <= pt0.brightness;
    mode1  <= pt0.play_mode;
    mode2  <= mode1;
    mode3  <= mode2;
    frames <= frames_next;
  end

endmodule

/* rtl/hsb_checker.sv */
// port-level checks for the colour point to frames block, bound to the top level
// depends on hsb_pkg and hue_sat_brt_to_rgb_frames_top
`timescale 1ns / 1ps

module hsb_checker
  import hsb_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input point_t  point,
  input logic    done,
  input frames_t frames
);

  // every accepted item produces a result with done high
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##4 done)
    else $error("accepted item did not produce a result");

  // no result without an earlier accepted item
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 5))
    else $error("result without accepted item");

  // fade frames last long, hold frames short
  a_mode_time: assert property (@(posedge clk) disable iff (rst)
    done |-> (frames.frame_mode == FM_FADE && frames.frame_time == FT_LONG) ||
             (frames.frame_mode == FM_HOLD && frames.frame_time == FT_SHORT))
    else $error("frame mode and time disagree");

  // hold frames: red of the second frame is either black or a copy of the first
  a_hold_copy: assert property (@(posedge clk) disable iff (rst)
    (done && frames.frame_mode == FM_HOLD && frames.red_second != 9'd0) |->
      frames.red_second == frames.red_first)
    else $error("hold frame two is neither black nor a copy");

  // breathe frames never go fully dark
  a_fade_lit: assert property (@(posedge clk) disable iff (rst)
    (done && frames.frame_mode == FM_FADE) |->
      frames.red_second != 9'd0 && frames.green_second != 9'd0 &&
      frames.blue_second != 9'd0)
    else $error("fade frame two has a dark channel");

endmodule

bind hue_sat_brt_to_rgb_frames_top hsb_checker u_hsb_checker (.*);
